// ===== design/rda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rda_pkg
// shared constants, types and helpers of the register descriptor allocator
// ----------------------------------------------------------------------------
package rda_pkg;

  localparam int NUM_SLOTS      = 18;
  localparam int FIRST_SLOT_REG = 8;
  localparam int NAME_ID_WIDTH  = 16;
  localparam int OFFSET_WIDTH   = 16;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef logic [SLOT_W-1:0]        slot_idx_t;
  typedef logic [NAME_ID_WIDTH-1:0] id_t;
  typedef logic [OFFSET_WIDTH-1:0]  off_t;
  typedef logic [4:0]               reg_num_t;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_END   = 2'd3;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    id_t       id;
    off_t      off;
  } key_wr_t;

  function automatic reg_num_t reg_of_slot(slot_idx_t s);
    logic [5:0] sum;
    sum = 6'(FIRST_SLOT_REG) + 6'(s);
    return sum[4:0];
  endfunction

  function automatic reg_num_t reg_offset(reg_num_t r);
    return r - 5'(FIRST_SLOT_REG);
  endfunction

  function automatic logic reg_is_slot(reg_num_t r);
    return 6'(reg_offset(r)) < 6'(NUM_SLOTS);
  endfunction

  function automatic logic is_avoided(reg_num_t r, reg_num_t a1, reg_num_t a2);
    return ((a1 != 5'd0) && (r == a1)) || ((a2 != 5'd0) && (r == a2));
  endfunction

endpackage

// ===== design/rda_key_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rda_key_store
// slot key registers with one read port and the shared key comparator
// ----------------------------------------------------------------------------
module rda_key_store (
  input  logic              clk,
  input  rda_pkg::key_wr_t  wr,
  input  rda_pkg::slot_idx_t rd_addr,
  input  rda_pkg::id_t      cmp_id,
  input  rda_pkg::off_t     cmp_off,
  output rda_pkg::id_t      rd_id,
  output rda_pkg::off_t     rd_off,
  output logic              match
);
  import rda_pkg::*;

  id_t  key_id_r  [NUM_SLOTS];
  off_t key_off_r [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_id_r[wr.addr]  <= wr.id;
      key_off_r[wr.addr] <= wr.off;
    end
  end

  assign rd_id  = key_id_r[rd_addr];
  assign rd_off = key_off_r[rd_addr];
  assign match  = (rd_id == cmp_id) && (rd_off == cmp_off);

endmodule

// ===== design/register_descriptor_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_descriptor_allocator
// Maps variable keys onto a small set of registers with write-back spilling.
// Input channel (in_*): one transfer per request. Read and write accesses
// give one result; flush and end of function give one result per slot that
// is written back (none when nothing is dirty), the final one with out_last.
// An access walks the slots one per cycle through a single key comparator;
// a hit ends the walk early. A round-robin victim search follows when every
// slot is dirty or avoided, and a commit step ends the access, waiting while
// its result cannot be loaded.
// A flush snapshots the dirty set at its transfer, then walks the slots up to
// the last written-back one, one per cycle unless a result cannot be loaded.
// in_stall stays high until the request is finished.
// The result sits in an output register; a new request is taken while it
// waits, and the block holds at its next result while a waiting result is held by out_stall.
// Reset (synchronous, rst_n low) empties every slot, clears the dirty bits
// and the round-robin pointer, and drops any pending result.
// ----------------------------------------------------------------------------
module register_descriptor_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_var_id,
  input  logic               in_var_segment,
  input  logic signed [15:0] in_var_offset,
  input  logic [4:0]         in_avoid_first,
  input  logic [4:0]         in_avoid_second,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_reg_number,
  output logic               out_load_needed,
  output logic               out_spill_valid,
  output logic [15:0]        out_spill_var_id,
  output logic               out_spill_segment,
  output logic signed [15:0] out_spill_offset,
  output logic               out_last
);
  import rda_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_RR     = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  localparam slot_idx_t LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  logic [2:0]           state_r, state_nxt;
  slot_idx_t            idx_r, idx_nxt;
  slot_idx_t            victim_r, victim_nxt;
  slot_idx_t            free_idx_r, free_idx_nxt;
  slot_idx_t            clean_idx_r, clean_idx_nxt;
  logic                 free_found_r, free_found_nxt;
  logic                 clean_found_r, clean_found_nxt;
  logic                 hit_r, hit_nxt;
  reg_num_t             rr_reg_r, rr_reg_nxt;
  logic [4:0]           rr_cnt_r, rr_cnt_nxt;
  logic                 honor_r, honor_nxt;
  reg_num_t             evict_ptr_r, evict_ptr_nxt;
  logic [NUM_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [NUM_SLOTS-1:0] slot_dirty_r, slot_dirty_nxt;
  logic [NUM_SLOTS-1:0] slot_seg_r, slot_seg_nxt;
  logic [NUM_SLOTS-1:0] mask_r, mask_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [1:0] mode_q_r;
  id_t        id_q_r;
  off_t       off_q_r;
  logic       seg_q_r;
  reg_num_t   avoid1_r;
  reg_num_t   avoid2_r;

  logic [4:0]  out_reg_r;
  logic        out_load_r;
  logic        out_spill_r;
  logic [15:0] out_id_r;
  logic        out_seg_r;
  logic [15:0] out_off_r;
  logic        out_last_r;

  logic [4:0]  out_reg_nxt;
  logic        out_load_nxt;
  logic        out_spill_nxt;
  logic [15:0] out_id_nxt;
  logic        out_seg_nxt;
  logic [15:0] out_off_nxt;
  logic        out_last_nxt;
  logic        out_load_en;

  logic                 in_xfer;
  logic                 out_free;
  slot_idx_t            rd_addr;
  id_t                  rd_id;
  off_t                 rd_off;
  logic                 key_match;
  key_wr_t              key_wr;
  reg_num_t             cur_reg;
  reg_num_t             cand;
  reg_num_t             cand_off;
  logic                 cand_ok;
  logic                 scan_hit;
  logic [NUM_SLOTS-1:0] idx_bit;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign rd_addr  = (state_r == ST_COMMIT) ? victim_r : idx_r;
  assign cur_reg  = reg_of_slot(idx_r);
  assign cand     = rr_reg_r + 5'd1;
  assign cand_off = reg_offset(cand);
  assign cand_ok  = reg_is_slot(cand) && (!honor_r || !is_avoided(cand, avoid1_r, avoid2_r));
  assign scan_hit = slot_valid_r[idx_r] && key_match && (slot_seg_r[idx_r] == seg_q_r);
  assign idx_bit  = NUM_SLOTS'(1) << idx_r;

  assign key_wr.en   = (state_r == ST_COMMIT) && out_free && !hit_r;
  assign key_wr.addr = victim_r;
  assign key_wr.id   = id_q_r;
  assign key_wr.off  = off_q_r;

  rda_key_store u_key_store (
    .clk     (clk),
    .wr      (key_wr),
    .rd_addr (rd_addr),
    .cmp_id  (id_q_r),
    .cmp_off (off_q_r),
    .rd_id   (rd_id),
    .rd_off  (rd_off),
    .match   (key_match)
  );

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    victim_nxt      = victim_r;
    free_idx_nxt    = free_idx_r;
    clean_idx_nxt   = clean_idx_r;
    free_found_nxt  = free_found_r;
    clean_found_nxt = clean_found_r;
    hit_nxt         = hit_r;
    rr_reg_nxt      = rr_reg_r;
    rr_cnt_nxt      = rr_cnt_r;
    honor_nxt       = honor_r;
    evict_ptr_nxt   = evict_ptr_r;
    slot_valid_nxt  = slot_valid_r;
    slot_dirty_nxt  = slot_dirty_r;
    slot_seg_nxt    = slot_seg_r;
    mask_nxt        = mask_r;
    out_load_en     = 1'b0;
    out_reg_nxt     = out_reg_r;
    out_load_nxt    = 1'b0;
    out_spill_nxt   = 1'b0;
    out_id_nxt      = 16'd0;
    out_seg_nxt     = 1'b0;
    out_off_nxt     = 16'd0;
    out_last_nxt    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          idx_nxt = '0;
          if (in_mode == MODE_READ || in_mode == MODE_WRITE) begin
            free_found_nxt  = 1'b0;
            clean_found_nxt = 1'b0;
            state_nxt       = ST_SCAN;
          end else begin
            mask_nxt = slot_valid_r & slot_dirty_r &
                       ((in_mode == MODE_FLUSH) ? {NUM_SLOTS{1'b1}} : slot_seg_r);
            slot_valid_nxt = '0;
            slot_dirty_nxt = '0;
            state_nxt      = ST_FLUSH;
          end
        end
      end

      ST_SCAN: begin
        if (scan_hit) begin
          hit_nxt    = 1'b1;
          victim_nxt = idx_r;
          state_nxt  = ST_COMMIT;
        end else begin
          if (!free_found_r && !slot_valid_r[idx_r]) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          if (!clean_found_r && !slot_dirty_r[idx_r] &&
              !is_avoided(cur_reg, avoid1_r, avoid2_r)) begin
            clean_found_nxt = 1'b1;
            clean_idx_nxt   = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            hit_nxt = 1'b0;
            if (free_found_nxt) begin
              victim_nxt = free_idx_nxt;
              state_nxt  = ST_COMMIT;
            end else if (clean_found_nxt) begin
              victim_nxt = clean_idx_nxt;
              state_nxt  = ST_COMMIT;
            end else begin
              rr_reg_nxt = evict_ptr_r;
              rr_cnt_nxt = 5'd0;
              honor_nxt  = 1'b1;
              state_nxt  = ST_RR;
            end
          end else begin
            idx_nxt = idx_r + SLOT_W'(1);
          end
        end
      end

      ST_RR: begin
        if (cand_ok) begin
          evict_ptr_nxt = cand;
          victim_nxt    = cand_off[SLOT_W-1:0];
          state_nxt     = ST_COMMIT;
        end else begin
          rr_reg_nxt = cand;
          rr_cnt_nxt = rr_cnt_r + 5'd1;
          if (rr_cnt_r == 5'd31) begin
            honor_nxt = 1'b0;
          end
        end
      end

      ST_COMMIT: begin
        if (out_free) begin
          out_load_en  = 1'b1;
          out_reg_nxt  = reg_of_slot(victim_r);
          out_load_nxt = !hit_r && (mode_q_r == MODE_READ);
          if (!hit_r && slot_dirty_r[victim_r]) begin
            out_spill_nxt = 1'b1;
            out_id_nxt    = 16'(rd_id);
            out_seg_nxt   = slot_seg_r[victim_r];
            out_off_nxt   = 16'(rd_off);
          end
          if (!hit_r) begin
            slot_valid_nxt[victim_r] = 1'b1;
            slot_seg_nxt[victim_r]   = seg_q_r;
            slot_dirty_nxt[victim_r] = (mode_q_r == MODE_WRITE);
          end else if (mode_q_r == MODE_WRITE) begin
            slot_dirty_nxt[victim_r] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (mask_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (!mask_r[idx_r]) begin
          idx_nxt = idx_r + SLOT_W'(1);
        end else if (out_free) begin
          out_load_en   = 1'b1;
          out_reg_nxt   = cur_reg;
          out_spill_nxt = 1'b1;
          out_id_nxt    = 16'(rd_id);
          out_seg_nxt   = slot_seg_r[idx_r];
          out_off_nxt   = 16'(rd_off);
          out_last_nxt  = ((mask_r & ~idx_bit) == '0);
          mask_nxt      = mask_r & ~idx_bit;
          idx_nxt       = idx_r + SLOT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      victim_r      <= '0;
      free_idx_r    <= '0;
      clean_idx_r   <= '0;
      free_found_r  <= 1'b0;
      clean_found_r <= 1'b0;
      hit_r         <= 1'b0;
      rr_reg_r      <= '0;
      rr_cnt_r      <= '0;
      honor_r       <= 1'b1;
      evict_ptr_r   <= '0;
      slot_valid_r  <= '0;
      slot_dirty_r  <= '0;
      slot_seg_r    <= '0;
      mask_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      victim_r      <= victim_nxt;
      free_idx_r    <= free_idx_nxt;
      clean_idx_r   <= clean_idx_nxt;
      free_found_r  <= free_found_nxt;
      clean_found_r <= clean_found_nxt;
      hit_r         <= hit_nxt;
      rr_reg_r      <= rr_reg_nxt;
      rr_cnt_r      <= rr_cnt_nxt;
      honor_r       <= honor_nxt;
      evict_ptr_r   <= evict_ptr_nxt;
      slot_valid_r  <= slot_valid_nxt;
      slot_dirty_r  <= slot_dirty_nxt;
      slot_seg_r    <= slot_seg_nxt;
      mask_r        <= mask_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_q_r <= in_mode;
      id_q_r   <= NAME_ID_WIDTH'(in_var_id);
      off_q_r  <= OFFSET_WIDTH'($unsigned(in_var_offset));
      seg_q_r  <= in_var_segment;
      avoid1_r <= in_avoid_first;
      avoid2_r <= in_avoid_second;
    end
    if (out_load_en) begin
      out_reg_r   <= out_reg_nxt;
      out_load_r  <= out_load_nxt;
      out_spill_r <= out_spill_nxt;
      out_id_r    <= out_id_nxt;
      out_seg_r   <= out_seg_nxt;
      out_off_r   <= out_off_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reg_number    = out_reg_r;
  assign out_load_needed   = out_load_r;
  assign out_spill_valid   = out_spill_r;
  assign out_spill_var_id  = out_id_r;
  assign out_spill_segment = out_seg_r;
  assign out_spill_offset  = $signed(out_off_r);
  assign out_last          = out_last_r;

  // a dirty slot is always occupied
  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_dirty_r & ~slot_valid_r) == '0)
    else $error("dirty bit set on an empty slot");

  // flush and end of function empty every slot
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_mode == MODE_FLUSH || in_mode == MODE_END)) |=> (slot_valid_r == '0))
    else $error("slots still occupied after flush transfer");

  // round robin only runs with every slot occupied
  a_rr_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RR) |-> (&slot_valid_r))
    else $error("victim search started with a free slot");

  // no result overwrites one still waiting
  a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_load_en |-> !(out_valid_r && out_stall))
    else $error("result register loaded while stalled");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for register_descriptor_allocator. A queue of requests
// feeds a clocked driver. The predictor keeps its own copy of the slots, the
// dirty bits and the round-robin pointer, and queues the expected results.
// A clocked monitor compares each result transfer field by field. A directed
// part comes first: hits, misses, eviction with avoided registers, flush and
// end of function. Random traffic follows, with random idle bursts on both
// sides and one long receiver hold.
// ----------------------------------------------------------------------------
module testbench;
  import rda_pkg::*;

  typedef struct {
    logic [1:0] mode;
    id_t        id;
    logic       seg;
    off_t       off;
    reg_num_t   a1;
    reg_num_t   a2;
  } request_t;

  typedef struct {
    reg_num_t reg_num;
    logic     load;
    logic     spill;
    id_t      spill_id;
    logic     spill_seg;
    off_t     spill_off;
    logic     last;
  } alloc_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = MODE_READ;
  logic [15:0]        in_var_id = '0;
  logic               in_var_segment = 1'b0;
  logic signed [15:0] in_var_offset = '0;
  logic [4:0]         in_avoid_first = '0;
  logic [4:0]         in_avoid_second = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         out_reg_number;
  logic               out_load_needed;
  logic               out_spill_valid;
  logic [15:0]        out_spill_var_id;
  logic               out_spill_segment;
  logic signed [15:0] out_spill_offset;
  logic               out_last;

  request_t      request_q[$];
  alloc_result_t alloc_results_q[$];
  request_t      next_req;
  request_t      taken_req;
  alloc_result_t want;

  bit       slot_used[NUM_SLOTS];
  bit       slot_dirty[NUM_SLOTS];
  id_t      slot_id[NUM_SLOTS];
  logic     slot_seg[NUM_SLOTS];
  off_t     slot_off[NUM_SLOTS];
  reg_num_t rr_pointer;

  bit in_taken = 1'b0;
  bit steady_flow = 1'b0;
  bit hold_request = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int long_hold_left = 0;
  int mismatches = 0;
  int requests_taken = 0;
  int results_checked = 0;
  int loads_seen = 0;
  int writebacks_seen = 0;

  register_descriptor_allocator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_var_id         (in_var_id),
    .in_var_segment    (in_var_segment),
    .in_var_offset     (in_var_offset),
    .in_avoid_first    (in_avoid_first),
    .in_avoid_second   (in_avoid_second),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reg_number    (out_reg_number),
    .out_load_needed   (out_load_needed),
    .out_spill_valid   (out_spill_valid),
    .out_spill_var_id  (out_spill_var_id),
    .out_spill_segment (out_spill_segment),
    .out_spill_offset  (out_spill_offset),
    .out_last          (out_last)
  );

  function automatic reg_num_t slot_register(int s);
    return 5'(FIRST_SLOT_REG + s);
  endfunction

  function automatic int register_slot(reg_num_t r);
    reg_num_t d;
    d = r - 5'(FIRST_SLOT_REG);
    return (int'(d) < NUM_SLOTS) ? int'(d) : -1;
  endfunction

  function automatic bit avoid_hit(reg_num_t r, reg_num_t a1, reg_num_t a2);
    return (a1 != 5'd0 && r == a1) || (a2 != 5'd0 && r == a2);
  endfunction

  // clean slot first, else round robin over registers, avoidance dropped last
  function automatic int choose_victim(reg_num_t a1, reg_num_t a2);
    reg_num_t r;
    int t;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!slot_dirty[s] && !avoid_hit(slot_register(s), a1, a2)) return s;
    end
    for (int honor = 1; honor >= 0; honor--) begin
      for (int k = 1; k <= 32; k++) begin
        r = rr_pointer + 5'(k);
        t = register_slot(r);
        if (t >= 0 && (honor == 0 || !avoid_hit(r, a1, a2))) begin
          rr_pointer = r;
          return t;
        end
      end
    end
    return 0;
  endfunction

  function automatic alloc_result_t writeback_of(int s);
    alloc_result_t res;
    res = '{default: '0};
    res.spill     = 1'b1;
    res.spill_id  = slot_id[s];
    res.spill_seg = slot_seg[s];
    res.spill_off = slot_off[s];
    return res;
  endfunction

  function automatic void allocate_and_spill(request_t q);
    alloc_result_t res;
    alloc_result_t batch[$];
    int hit;
    res = '{default: '0};
    hit = -1;
    if (q.mode == MODE_READ || q.mode == MODE_WRITE) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (hit < 0 && slot_used[s] && slot_id[s] == q.id && slot_seg[s] == q.seg &&
            slot_off[s] == q.off) hit = s;
      end
      if (hit < 0) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (hit < 0 && !slot_used[s]) hit = s;
        end
        if (hit < 0) begin
          hit = choose_victim(q.a1, q.a2);
          if (slot_dirty[hit]) res = writeback_of(hit);
        end
        slot_used[hit] = 1'b1;
        slot_id[hit]   = q.id;
        slot_seg[hit]  = q.seg;
        slot_off[hit]  = q.off;
        if (q.mode == MODE_READ) begin
          slot_dirty[hit] = 1'b0;
          res.load = 1'b1;
        end
      end
      if (q.mode == MODE_WRITE) slot_dirty[hit] = 1'b1;
      res.reg_num = slot_register(hit);
      res.last    = 1'b1;
      alloc_results_q.push_back(res);
    end else begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (slot_used[s] && slot_dirty[s] && (q.mode == MODE_FLUSH || slot_seg[s])) begin
          res = writeback_of(s);
          res.reg_num = slot_register(s);
          batch.push_back(res);
        end
        slot_used[s]  = 1'b0;
        slot_dirty[s] = 1'b0;
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) alloc_results_q.push_back(batch[i]);
    end
  endfunction

  function automatic request_t make_request(logic [1:0] mode, id_t id, logic seg, off_t off,
                                            reg_num_t a1, reg_num_t a2);
    request_t q;
    q.mode = mode;
    q.id   = id;
    q.seg  = seg;
    q.off  = off;
    q.a1   = a1;
    q.a2   = a2;
    return q;
  endfunction

  function automatic reg_num_t rand_avoid();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 5'd0;
    if (pick < 9) return 5'($urandom_range(FIRST_SLOT_REG, FIRST_SLOT_REG + NUM_SLOTS - 1));
    return 5'($urandom_range(0, 31));
  endfunction

  // mostly a small working set a bit larger than the slot count, some noise keys
  function automatic request_t rand_request();
    request_t q;
    int pick;
    pick = $urandom_range(0, 99);
    q.mode = (pick < 5) ? MODE_FLUSH : (pick < 10) ? MODE_END :
             (pick < 55) ? MODE_READ : MODE_WRITE;
    if ($urandom_range(0, 9) == 0) begin
      q.id  = id_t'($urandom);
      q.seg = 1'($urandom);
      q.off = off_t'($urandom);
    end else begin
      q.id  = id_t'($urandom_range(0, 23));
      q.seg = ($urandom_range(0, 4) == 0) ? ~q.id[0] : q.id[0];
      q.off = off_t'(q.id << 2);
    end
    q.a1 = rand_avoid();
    q.a2 = rand_avoid();
    return q;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || alloc_results_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else begin
        next_req = request_q.pop_front();
        in_valid        <= 1'b1;
        in_mode         <= next_req.mode;
        in_var_id       <= next_req.id;
        in_var_segment  <= next_req.seg;
        in_var_offset   <= next_req.off;
        in_avoid_first  <= next_req.a1;
        in_avoid_second <= next_req.a2;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      long_hold_left = 399;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      taken_req.mode = in_mode;
      taken_req.id   = in_var_id;
      taken_req.seg  = in_var_segment;
      taken_req.off  = in_var_offset;
      taken_req.a1   = in_avoid_first;
      taken_req.a2   = in_avoid_second;
      allocate_and_spill(taken_req);
      in_taken = 1'b1;
      requests_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (alloc_results_q.size() == 0) begin
        $error("result transfer with nothing expected: reg_number %0d", out_reg_number);
        mismatches++;
      end else begin
        want = alloc_results_q.pop_front();
        check_field("reg_number", 16'(want.reg_num), 16'(out_reg_number));
        check_field("load_needed", 16'(want.load), 16'(out_load_needed));
        check_field("spill_valid", 16'(want.spill), 16'(out_spill_valid));
        check_field("spill_var_id", want.spill_id, out_spill_var_id);
        check_field("spill_segment", 16'(want.spill_seg), 16'(out_spill_segment));
        check_field("spill_offset", want.spill_off, out_spill_offset);
        check_field("last", 16'(want.last), 16'(out_last));
        results_checked++;
        if (want.load) loads_seen++;
        if (want.spill) writebacks_seen++;
      end
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_used[s]  = 1'b0;
      slot_dirty[s] = 1'b0;
      slot_id[s]    = '0;
      slot_seg[s]   = 1'b0;
      slot_off[s]   = '0;
    end
    rr_pointer = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // flush of an empty store, then hits and misses on extreme keys
    request_q.push_back(make_request(MODE_FLUSH, 16'h5a5a, 1'b1, 16'h0010, 5'd0, 5'd0));
    request_q.push_back(make_request(MODE_READ, 16'h0000, 1'b0, 16'h8000, 5'd0, 5'd0));
    request_q.push_back(make_request(MODE_WRITE, 16'h0000, 1'b0, 16'h8000, 5'd0, 5'd0));
    request_q.push_back(make_request(MODE_READ, 16'h0000, 1'b0, 16'h8000, 5'd0, 5'd0));
    request_q.push_back(make_request(MODE_WRITE, 16'hffff, 1'b1, 16'h7ffc, 5'd31, 5'd31));
    request_q.push_back(make_request(MODE_READ, 16'h1234, 1'b1, 16'h0003, 5'd0, 5'd0));
    for (int i = 0; i < NUM_SLOTS - 3; i++) begin
      request_q.push_back(make_request(MODE_WRITE, id_t'(100 + i), 1'(i), off_t'(i * 4),
                                       5'd0, 5'd0));
    end
    // store full: avoided clean slot, round-robin spills, then a clean replacement
    request_q.push_back(make_request(MODE_WRITE, 16'd200, 1'b1, 16'h0000, 5'd10, 5'd0));
    request_q.push_back(make_request(MODE_READ, 16'd201, 1'b0, 16'h0004, 5'd0, 5'd10));
    request_q.push_back(make_request(MODE_READ, 16'd202, 1'b1, 16'h0008, 5'd9, 5'd10));
    request_q.push_back(make_request(MODE_WRITE, 16'd203, 1'b0, 16'h000c, 5'd0, 5'd0));
    request_q.push_back(make_request(MODE_END, 16'd0, 1'b0, 16'h0000, 5'd0, 5'd0));
    request_q.push_back(make_request(MODE_WRITE, 16'd5, 1'b1, 16'h0014, 5'd0, 5'd0));
    request_q.push_back(make_request(MODE_WRITE, 16'd6, 1'b0, 16'hfff8, 5'd0, 5'd0));
    request_q.push_back(make_request(MODE_FLUSH, 16'd0, 1'b0, 16'h0000, 5'd0, 5'd0));
    wait_drained();

    // receiver holds off while requests keep coming
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) request_q.push_back(rand_request());
    wait_drained();
    for (int i = 0; i < 60; i++) request_q.push_back(rand_request());
    wait_drained();
    steady_flow = 1'b1;
    for (int i = 0; i < 60; i++) request_q.push_back(rand_request());
    wait_drained();
    repeat (100) @(posedge clk);

    $display("checked %0d results from %0d requests: %0d loads, %0d write-backs",
             results_checked, requests_taken, loads_seen, writebacks_seen);
    $display("covered hits, misses, avoided eviction, flush and end of function under stalls");
    if (mismatches == 0 && alloc_results_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== register_descriptor_allocator.f =====
design/rda_pkg.sv
design/rda_key_store.sv
design/register_descriptor_allocator.sv
tb/testbench.sv
